FILE: hdl/sic_pkg.sv
`timescale 1ns / 1ps

package sic_pkg;

   // Class codes of the rsp_relation field.
   typedef enum logic [1:0] {
      REL_DISJOINT = 2'd0,
      REL_POINT    = 2'd1,
      REL_OVERLAP  = 2'd2,
      REL_CONTAIN  = 2'd3
   } relation_type;

   // Lexicographic order of the sorted endpoints, needed for the collinear case.
   typedef struct packed {
      logic b_lt_c;
      logic b_eq_c;
      logic a_lt_c;
      logic b_lt_d;
   } order_type;

   // Endpoint slots in the point arrays.
   localparam int unsigned PT_A = 0;
   localparam int unsigned PT_B = 1;
   localparam int unsigned PT_C = 2;
   localparam int unsigned PT_D = 3;
   localparam int unsigned PT_COUNT = 4;

endpackage

FILE: hdl/segment_intersection_classifier.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_a_x .. req_d_y, 32-bit signed each
// rsp_      out        rsp_valid/rsp_stall  rsp_relation, 2-bit class code
//
// One segment pair is taken per cycle while req_stall is low.
// The five register stages are: endpoint sort, segment exchange, coordinate
// differences, the eight cross-product multipliers, and the sign/class stage.
// Reset (synchronous, active high) clears only the stage valid bits.
// A stage advances when it is empty or the stage after it advances, so a stall
// on rsp_ backs up only as far as the bubbles allow; nothing is lost or repeated.

module segment_intersection_classifier #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_c_x,
   input  logic signed [31:0] req_c_y,
   input  logic signed [31:0] req_d_x,
   input  logic signed [31:0] req_d_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_relation
);

   // Differences need one bit more than a coordinate, a product twice that,
   // and the difference of two products one bit more again, so every
   // orientation is exact.
   localparam int unsigned DW = COORD_WIDTH + 1;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned XW = PW + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DW-1:0]          diff_type;
   typedef logic signed [PW-1:0]          prod_type;
   typedef logic signed [XW-1:0]          cross_type;

   // True when point (px, py) comes strictly before (qx, qy): x first, then y.
   function automatic logic pt_less(input coord_type px, input coord_type py,
                                    input coord_type qx, input coord_type qy);
      return (px < qx) || ((px == qx) && (py < qy));
   endfunction

   function automatic diff_type diff_of(input coord_type p, input coord_type q);
      return DW'(p) - DW'(q);
   endfunction

   function automatic prod_type prod_of(input diff_type u, input diff_type v);
      return PW'(u) * PW'(v);
   endfunction

   // ---------------------------------------------------------------------
   // Flow control. Each stage loads when it is empty or its successor loads.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: keep the low COORD_WIDTH bits of every coordinate as a signed
   // value and put the endpoints of each segment in lexicographic order.
   // ---------------------------------------------------------------------
   coord_type raw_x [sic_pkg::PT_COUNT];
   coord_type raw_y [sic_pkg::PT_COUNT];
   coord_type s1_x_in [sic_pkg::PT_COUNT];
   coord_type s1_y_in [sic_pkg::PT_COUNT];
   coord_type s1_x_ff [sic_pkg::PT_COUNT];
   coord_type s1_y_ff [sic_pkg::PT_COUNT];
   logic      swap_ab, swap_cd;

   always_comb begin
      raw_x[sic_pkg::PT_A] = coord_type'(req_a_x[COORD_WIDTH-1:0]);
      raw_y[sic_pkg::PT_A] = coord_type'(req_a_y[COORD_WIDTH-1:0]);
      raw_x[sic_pkg::PT_B] = coord_type'(req_b_x[COORD_WIDTH-1:0]);
      raw_y[sic_pkg::PT_B] = coord_type'(req_b_y[COORD_WIDTH-1:0]);
      raw_x[sic_pkg::PT_C] = coord_type'(req_c_x[COORD_WIDTH-1:0]);
      raw_y[sic_pkg::PT_C] = coord_type'(req_c_y[COORD_WIDTH-1:0]);
      raw_x[sic_pkg::PT_D] = coord_type'(req_d_x[COORD_WIDTH-1:0]);
      raw_y[sic_pkg::PT_D] = coord_type'(req_d_y[COORD_WIDTH-1:0]);

      swap_ab = pt_less(raw_x[sic_pkg::PT_B], raw_y[sic_pkg::PT_B],
                        raw_x[sic_pkg::PT_A], raw_y[sic_pkg::PT_A]);
      swap_cd = pt_less(raw_x[sic_pkg::PT_D], raw_y[sic_pkg::PT_D],
                        raw_x[sic_pkg::PT_C], raw_y[sic_pkg::PT_C]);

      s1_x_in[sic_pkg::PT_A] = swap_ab ? raw_x[sic_pkg::PT_B] : raw_x[sic_pkg::PT_A];
      s1_y_in[sic_pkg::PT_A] = swap_ab ? raw_y[sic_pkg::PT_B] : raw_y[sic_pkg::PT_A];
      s1_x_in[sic_pkg::PT_B] = swap_ab ? raw_x[sic_pkg::PT_A] : raw_x[sic_pkg::PT_B];
      s1_y_in[sic_pkg::PT_B] = swap_ab ? raw_y[sic_pkg::PT_A] : raw_y[sic_pkg::PT_B];
      s1_x_in[sic_pkg::PT_C] = swap_cd ? raw_x[sic_pkg::PT_D] : raw_x[sic_pkg::PT_C];
      s1_y_in[sic_pkg::PT_C] = swap_cd ? raw_y[sic_pkg::PT_D] : raw_y[sic_pkg::PT_C];
      s1_x_in[sic_pkg::PT_D] = swap_cd ? raw_x[sic_pkg::PT_C] : raw_x[sic_pkg::PT_D];
      s1_y_in[sic_pkg::PT_D] = swap_cd ? raw_y[sic_pkg::PT_C] : raw_y[sic_pkg::PT_D];
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_x_ff <= s1_x_in;
         s1_y_ff <= s1_y_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: exchange the segments when C comes before A, so that A is the
   // smallest of all four endpoints.
   // ---------------------------------------------------------------------
   coord_type s2_x_in [sic_pkg::PT_COUNT];
   coord_type s2_y_in [sic_pkg::PT_COUNT];
   coord_type s2_x_ff [sic_pkg::PT_COUNT];
   coord_type s2_y_ff [sic_pkg::PT_COUNT];
   logic      swap_seg;

   always_comb begin
      swap_seg = pt_less(s1_x_ff[sic_pkg::PT_C], s1_y_ff[sic_pkg::PT_C],
                         s1_x_ff[sic_pkg::PT_A], s1_y_ff[sic_pkg::PT_A]);
      s2_x_in[sic_pkg::PT_A] = swap_seg ? s1_x_ff[sic_pkg::PT_C] : s1_x_ff[sic_pkg::PT_A];
      s2_y_in[sic_pkg::PT_A] = swap_seg ? s1_y_ff[sic_pkg::PT_C] : s1_y_ff[sic_pkg::PT_A];
      s2_x_in[sic_pkg::PT_B] = swap_seg ? s1_x_ff[sic_pkg::PT_D] : s1_x_ff[sic_pkg::PT_B];
      s2_y_in[sic_pkg::PT_B] = swap_seg ? s1_y_ff[sic_pkg::PT_D] : s1_y_ff[sic_pkg::PT_B];
      s2_x_in[sic_pkg::PT_C] = swap_seg ? s1_x_ff[sic_pkg::PT_A] : s1_x_ff[sic_pkg::PT_C];
      s2_y_in[sic_pkg::PT_C] = swap_seg ? s1_y_ff[sic_pkg::PT_A] : s1_y_ff[sic_pkg::PT_C];
      s2_x_in[sic_pkg::PT_D] = swap_seg ? s1_x_ff[sic_pkg::PT_B] : s1_x_ff[sic_pkg::PT_D];
      s2_y_in[sic_pkg::PT_D] = swap_seg ? s1_y_ff[sic_pkg::PT_B] : s1_y_ff[sic_pkg::PT_D];
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_x_ff <= s2_x_in;
         s2_y_ff <= s2_y_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: coordinate differences for the four orientations, and the
   // endpoint order flags that the collinear case needs.
   //   orient(p, q, r) = (qx - px) * (ry - py) - (qy - py) * (rx - px)
   // AB against C and D, then CD against A and B.
   // ---------------------------------------------------------------------
   diff_type bax_ff, bay_ff, cay_ff, cax_ff, day_ff, dax_ff;
   diff_type dcx_ff, dcy_ff, acy_ff, acx_ff, bcy_ff, bcx_ff;
   sic_pkg::order_type s3_order_in, s3_order_ff;

   always_comb begin
      s3_order_in.b_lt_c = pt_less(s2_x_ff[sic_pkg::PT_B], s2_y_ff[sic_pkg::PT_B],
                                   s2_x_ff[sic_pkg::PT_C], s2_y_ff[sic_pkg::PT_C]);
      s3_order_in.b_eq_c = (s2_x_ff[sic_pkg::PT_B] == s2_x_ff[sic_pkg::PT_C]) &&
                           (s2_y_ff[sic_pkg::PT_B] == s2_y_ff[sic_pkg::PT_C]);
      s3_order_in.a_lt_c = pt_less(s2_x_ff[sic_pkg::PT_A], s2_y_ff[sic_pkg::PT_A],
                                   s2_x_ff[sic_pkg::PT_C], s2_y_ff[sic_pkg::PT_C]);
      s3_order_in.b_lt_d = pt_less(s2_x_ff[sic_pkg::PT_B], s2_y_ff[sic_pkg::PT_B],
                                   s2_x_ff[sic_pkg::PT_D], s2_y_ff[sic_pkg::PT_D]);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         bax_ff <= diff_of(s2_x_ff[sic_pkg::PT_B], s2_x_ff[sic_pkg::PT_A]);
         bay_ff <= diff_of(s2_y_ff[sic_pkg::PT_B], s2_y_ff[sic_pkg::PT_A]);
         cay_ff <= diff_of(s2_y_ff[sic_pkg::PT_C], s2_y_ff[sic_pkg::PT_A]);
         cax_ff <= diff_of(s2_x_ff[sic_pkg::PT_C], s2_x_ff[sic_pkg::PT_A]);
         day_ff <= diff_of(s2_y_ff[sic_pkg::PT_D], s2_y_ff[sic_pkg::PT_A]);
         dax_ff <= diff_of(s2_x_ff[sic_pkg::PT_D], s2_x_ff[sic_pkg::PT_A]);
         dcx_ff <= diff_of(s2_x_ff[sic_pkg::PT_D], s2_x_ff[sic_pkg::PT_C]);
         dcy_ff <= diff_of(s2_y_ff[sic_pkg::PT_D], s2_y_ff[sic_pkg::PT_C]);
         acy_ff <= diff_of(s2_y_ff[sic_pkg::PT_A], s2_y_ff[sic_pkg::PT_C]);
         acx_ff <= diff_of(s2_x_ff[sic_pkg::PT_A], s2_x_ff[sic_pkg::PT_C]);
         bcy_ff <= diff_of(s2_y_ff[sic_pkg::PT_B], s2_y_ff[sic_pkg::PT_C]);
         bcx_ff <= diff_of(s2_x_ff[sic_pkg::PT_B], s2_x_ff[sic_pkg::PT_C]);
         s3_order_ff <= s3_order_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: the eight products, each its own multiplier, registered.
   // ---------------------------------------------------------------------
   prod_type abc_p_ff, abc_q_ff, abd_p_ff, abd_q_ff;
   prod_type cda_p_ff, cda_q_ff, cdb_p_ff, cdb_q_ff;
   sic_pkg::order_type s4_order_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         abc_p_ff <= prod_of(bax_ff, cay_ff);
         abc_q_ff <= prod_of(bay_ff, cax_ff);
         abd_p_ff <= prod_of(bax_ff, day_ff);
         abd_q_ff <= prod_of(bay_ff, dax_ff);
         cda_p_ff <= prod_of(dcx_ff, acy_ff);
         cda_q_ff <= prod_of(dcy_ff, acx_ff);
         cdb_p_ff <= prod_of(dcx_ff, bcy_ff);
         cdb_q_ff <= prod_of(dcy_ff, bcx_ff);
         s4_order_ff <= s3_order_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: exact cross products, their signs, and the class code.
   // ---------------------------------------------------------------------
   cross_type abc_x, abd_x, cda_x, cdb_x;
   logic abc_pos, abc_neg, abd_pos, abd_neg;
   logic cda_pos, cda_neg, cdb_pos, cdb_neg;
   logic straddle, collinear;
   sic_pkg::relation_type relation_in, relation_ff;

   always_comb begin
      abc_x = XW'(abc_p_ff) - XW'(abc_q_ff);
      abd_x = XW'(abd_p_ff) - XW'(abd_q_ff);
      cda_x = XW'(cda_p_ff) - XW'(cda_q_ff);
      cdb_x = XW'(cdb_p_ff) - XW'(cdb_q_ff);

      abc_neg = abc_x[XW-1];
      abd_neg = abd_x[XW-1];
      cda_neg = cda_x[XW-1];
      cdb_neg = cdb_x[XW-1];
      abc_pos = !abc_neg && (|abc_x);
      abd_pos = !abd_neg && (|abd_x);
      cda_pos = !cda_neg && (|cda_x);
      cdb_pos = !cdb_neg && (|cdb_x);

      // Neither segment has both endpoints of the other strictly on one side.
      straddle = !((abc_pos && abd_pos) || (abc_neg && abd_neg)) &&
                 !((cda_pos && cdb_pos) || (cda_neg && cdb_neg));
      collinear = !(|abc_x) && !(|abd_x) && !(|cda_x) && !(|cdb_x);

      if (!straddle) begin
         relation_in = sic_pkg::REL_DISJOINT;
      end else if (!collinear) begin
         relation_in = sic_pkg::REL_POINT;
      end else if (s4_order_ff.b_lt_c) begin
         relation_in = sic_pkg::REL_DISJOINT;
      end else if (s4_order_ff.b_eq_c) begin
         relation_in = sic_pkg::REL_POINT;
      end else if (s4_order_ff.a_lt_c && s4_order_ff.b_lt_d) begin
         relation_in = sic_pkg::REL_OVERLAP;
      end else begin
         relation_in = sic_pkg::REL_CONTAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         relation_ff <= relation_in;
      end
   end

   assign rsp_relation = relation_ff;

endmodule

FILE: hdl/sic_checker.sv
`timescale 1ns / 1ps

module sic_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_relation
);

   logic idle;
   assign idle = !(req_valid && !req_stall) && !rsp_stall;

   // A held result keeps its class until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_relation))
      else $error("held result changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only a stalled, full output can push back on the input.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output can drain");

   // Without new input and without output stall, the pipeline drains every stage.
   assert property (@(posedge clock) disable iff (reset)
      idle ##1 idle ##1 idle ##1 idle ##1 idle |=> !rsp_valid)
      else $error("pipeline did not drain");

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (.*);
